// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the multitouch slot tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MTS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/mts_pkg.sv -----
// Package: constants and types of the multitouch slot tracker.
package mts_pkg;

	// Default number of slot storage entries
	localparam int SLOT_DEPTH_DEF = 16;
	// Contacts reported per frame at most
	localparam int MAX_RESULTS   = 16;
	localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);

	// Event types and axis codes
	localparam logic [15:0] TYPE_SYNC  = 16'h0000;
	localparam logic [15:0] TYPE_ABS   = 16'h0003;
	localparam logic [15:0] CODE_SLOT  = 16'h002f;
	localparam logic [15:0] CODE_TRACK = 16'h0039;
	localparam logic [15:0] CODE_X     = 16'h0035;
	localparam logic [15:0] CODE_Y     = 16'h0036;

	// Tracking id markers
	localparam logic [31:0] ID_RELEASED = 32'hFFFF_FFFF;
	localparam logic [31:0] ID_IDLE     = 32'hFFFF_FFFE;

	localparam logic [4:0] SLOT_COUNT_RST = 5'd16;

	// Write enables of the three slot stores
	typedef struct packed {
		logic id_we;
		logic x_we;
		logic y_we;
	} ram_we_t;

endpackage

// ----- rtl/core/mts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/mts_seq.sv -----
// Event decoder and slot scan sequencer with the result register.
module mts_seq #(
	parameter int SLOT_DEPTH = mts_pkg::SLOT_DEPTH_DEF,
	parameter int SW         = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	// slot count register
	input  logic                slot_count_we,
	input  logic [4:0]          slot_count_wdata,
	// event channel
	input  logic                event_valid,
	output logic                event_ready,
	input  logic [15:0]         event_type,
	input  logic [15:0]         event_code,
	input  logic signed [31:0]  event_value,
	// result channel
	output logic                result_valid,
	input  logic                result_ready,
	output logic                has_contact,
	output logic [3:0]          contact_slot,
	output logic signed [31:0]  contact_id,
	output logic signed [31:0]  contact_x,
	output logic signed [31:0]  contact_y,
	output logic                frame_last,
	// slot stores
	output mts_pkg::ram_we_t    ram_we,
	output logic [SW-1:0]       ram_waddr,
	output logic [31:0]         ram_wdata,
	output logic [SW-1:0]       ram_raddr,
	input  logic [31:0]         id_rdata,
	input  logic [31:0]         x_rdata,
	input  logic [31:0]         y_rdata
);

	import mts_pkg::*;

	localparam int CW = $clog2(SLOT_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_FINISH
	} state_t;

	state_t                 state_q;
	logic [4:0]             slot_count_q;
	logic [31:0]            cur_slot_q;
	logic [CW-1:0]          idx_q;
	logic [RES_CNT_W-1:0]   cnt_q;
	logic [SLOT_DEPTH-1:0]  touched_q;
	logic [SLOT_DEPTH-1:0]  id_wr_q;
	logic [SLOT_DEPTH-1:0]  x_wr_q;
	logic [SLOT_DEPTH-1:0]  y_wr_q;

	// contact held back until it is known whether it closes the frame
	logic                   pend_valid_q;
	logic [3:0]             pend_slot_q;
	logic [31:0]            pend_id_q;
	logic [31:0]            pend_x_q;
	logic [31:0]            pend_y_q;

	logic                   result_valid_q;
	logic                   has_contact_q;
	logic [3:0]             contact_slot_q;
	logic [31:0]            contact_id_q;
	logic [31:0]            contact_x_q;
	logic [31:0]            contact_y_q;
	logic                   frame_last_q;

	logic [CW-1:0]          n_slots;
	logic                   cur_in_range;
	logic [SW-1:0]          cur_idx;
	logic [SW-1:0]          idx;
	logic                   accept;
	logic                   is_abs;
	logic                   is_sync;
	logic                   upd;
	logic                   out_free;
	logic                   scan_done;
	logic [31:0]            chk_id;
	logic [31:0]            chk_x;
	logic [31:0]            chk_y;
	logic                   chk_report;
	logic                   chk_go;

	// effective slot count, clamped to the storage depth
	always_comb begin
		if (32'(slot_count_q) > 32'(SLOT_DEPTH)) begin
			n_slots = CW'(SLOT_DEPTH);
		end else begin
			n_slots = CW'(slot_count_q);
		end
	end

	assign cur_in_range = !cur_slot_q[31] && (cur_slot_q < 32'(n_slots));
	assign cur_idx      = cur_slot_q[SW-1:0];
	assign idx          = idx_q[SW-1:0];

	// event decode
	assign event_ready = (state_q == ST_IDLE);
	assign accept      = event_valid && event_ready;
	assign is_abs      = (event_type == TYPE_ABS);
	assign is_sync     = (event_type == TYPE_SYNC);
	assign upd         = accept && is_abs && cur_in_range;

	// slot store writes go to the current slot
	assign ram_we.id_we = upd && (event_code == CODE_TRACK);
	assign ram_we.x_we  = upd && (event_code == CODE_X);
	assign ram_we.y_we  = upd && (event_code == CODE_Y);
	assign ram_waddr    = cur_idx;
	assign ram_wdata    = event_value;
	assign ram_raddr    = idx;

	// scan step: ids not written since reset or the last sync, and X or Y never written since reset, read as reset value
	assign out_free   = !result_valid_q || result_ready;
	assign scan_done  = (idx_q >= n_slots);
	assign chk_id     = id_wr_q[idx] ? id_rdata : ID_IDLE;
	assign chk_x      = x_wr_q[idx] ? x_rdata : 32'd0;
	assign chk_y      = y_wr_q[idx] ? y_rdata : 32'd0;
	assign chk_report = (chk_id != ID_RELEASED) && (cnt_q < RES_CNT_W'(MAX_RESULTS));
	// a new contact can only displace the held one when the result register is free
	assign chk_go     = !(chk_report && pend_valid_q && !out_free);

	// sequencer, slot flags and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			slot_count_q   <= SLOT_COUNT_RST;
			cur_slot_q     <= '0;
			idx_q          <= '0;
			cnt_q          <= '0;
			touched_q      <= '0;
			id_wr_q        <= '0;
			x_wr_q         <= '0;
			y_wr_q         <= '0;
			pend_valid_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (slot_count_we) begin
				slot_count_q <= slot_count_wdata;
			end
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && is_abs) begin
						if (event_code == CODE_SLOT) begin
							cur_slot_q <= event_value;
						end else if (cur_in_range) begin
							if (event_code == CODE_TRACK) begin
								touched_q[cur_idx] <= 1'b1;
								id_wr_q[cur_idx]   <= 1'b1;
							end else if (event_code == CODE_X) begin
								touched_q[cur_idx] <= 1'b1;
								x_wr_q[cur_idx]    <= 1'b1;
							end else if (event_code == CODE_Y) begin
								touched_q[cur_idx] <= 1'b1;
								y_wr_q[cur_idx]    <= 1'b1;
							end
						end
					end else if (accept && is_sync) begin
						idx_q        <= '0;
						cnt_q        <= '0;
						pend_valid_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_FINISH;
					end else if (touched_q[idx]) begin
						state_q <= ST_CHECK;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_CHECK: begin
					if (chk_go) begin
						touched_q[idx] <= 1'b0;
						id_wr_q[idx]   <= 1'b0;
						idx_q          <= idx_q + CW'(1);
						state_q        <= ST_SCAN;
						if (chk_report) begin
							cnt_q        <= cnt_q + RES_CNT_W'(1);
							pend_valid_q <= 1'b1;
							pend_slot_q  <= 4'(idx_q);
							pend_id_q    <= chk_id;
							pend_x_q     <= chk_x;
							pend_y_q     <= chk_y;
							// the held contact is now known not to be the last
							if (pend_valid_q) begin
								result_valid_q <= 1'b1;
								has_contact_q  <= 1'b1;
								contact_slot_q <= pend_slot_q;
								contact_id_q   <= pend_id_q;
								contact_x_q    <= pend_x_q;
								contact_y_q    <= pend_y_q;
								frame_last_q   <= 1'b0;
							end
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						frame_last_q   <= 1'b1;
						if (pend_valid_q) begin
							has_contact_q  <= 1'b1;
							contact_slot_q <= pend_slot_q;
							contact_id_q   <= pend_id_q;
							contact_x_q    <= pend_x_q;
							contact_y_q    <= pend_y_q;
						end else begin
							// empty frame marker
							has_contact_q  <= 1'b0;
							contact_slot_q <= '0;
							contact_id_q   <= '0;
							contact_x_q    <= '0;
							contact_y_q    <= '0;
						end
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign has_contact  = has_contact_q;
	assign contact_slot = contact_slot_q;
	assign contact_id   = contact_id_q;
	assign contact_x    = contact_x_q;
	assign contact_y    = contact_y_q;
	assign frame_last   = frame_last_q;

endmodule

// ----- rtl/core/multitouch_slot_tracker.sv -----
// Top level of the multitouch slot tracker: sequencer, slot stores and checks.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------------------
//  event    | event_valid / event_ready    | event_type, event_code, event_value
//  result   | result_valid / result_ready  | has_contact, contact_slot, contact_id,
//           |                              | contact_x, contact_y, frame_last
//  config   | slot_count_we (no wait)      | slot_count_wdata
//
// Slot, tracking id, X, Y and ignored events are accepted whenever the sequencer is idle.
// A sync event holds event_ready low while the scan runs: one scan step per slot of the
// effective slot count plus one to see the end, one check step per touched slot for the
// registered read, and one finish step for the last result.
// A stalled result channel holds the scan at the next contact or at the last result.
// Reset: slot count 16, current slot 0, all slots untouched, id -2, X and Y 0.
`include "assert_macros.svh"

module multitouch_slot_tracker #(
	parameter int SLOT_DEPTH = mts_pkg::SLOT_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               slot_count_we,
	input  logic [4:0]         slot_count_wdata,
	input  logic               event_valid,
	output logic               event_ready,
	input  logic [15:0]        event_type,
	input  logic [15:0]        event_code,
	input  logic signed [31:0] event_value,
	output logic               result_valid,
	input  logic               result_ready,
	output logic               has_contact,
	output logic [3:0]         contact_slot,
	output logic signed [31:0] contact_id,
	output logic signed [31:0] contact_x,
	output logic signed [31:0] contact_y,
	output logic               frame_last
);

	import mts_pkg::*;

	localparam int SW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

	ram_we_t       ram_we;
	logic [SW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [SW-1:0] ram_raddr;
	logic [31:0]   id_rdata;
	logic [31:0]   x_rdata;
	logic [31:0]   y_rdata;
	logic          evt_acc;
	logic          store_we;
	logic          res_contact;

	// event decode and scan sequencer
	mts_seq #(
		.SLOT_DEPTH (SLOT_DEPTH),
		.SW         (SW)
	) u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.slot_count_we    (slot_count_we),
		.slot_count_wdata (slot_count_wdata),
		.event_valid      (event_valid),
		.event_ready      (event_ready),
		.event_type       (event_type),
		.event_code       (event_code),
		.event_value      (event_value),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.has_contact      (has_contact),
		.contact_slot     (contact_slot),
		.contact_id       (contact_id),
		.contact_x        (contact_x),
		.contact_y        (contact_y),
		.frame_last       (frame_last),
		.ram_we           (ram_we),
		.ram_waddr        (ram_waddr),
		.ram_wdata        (ram_wdata),
		.ram_raddr        (ram_raddr),
		.id_rdata         (id_rdata),
		.x_rdata          (x_rdata),
		.y_rdata          (y_rdata)
	);

	// per-slot tracking id store
	mts_ram #(
		.WIDTH (32),
		.DEPTH (SLOT_DEPTH),
		.AW    (SW)
	) u_id_ram (
		.clk   (clk),
		.we    (ram_we.id_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (id_rdata)
	);

	// per-slot X store
	mts_ram #(
		.WIDTH (32),
		.DEPTH (SLOT_DEPTH),
		.AW    (SW)
	) u_x_ram (
		.clk   (clk),
		.we    (ram_we.x_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (x_rdata)
	);

	// per-slot Y store
	mts_ram #(
		.WIDTH (32),
		.DEPTH (SLOT_DEPTH),
		.AW    (SW)
	) u_y_ram (
		.clk   (clk),
		.we    (ram_we.y_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (y_rdata)
	);

	// checks
	assign evt_acc     = event_valid && event_ready;
	assign store_we    = ram_we.id_we || ram_we.x_we || ram_we.y_we;
	assign res_contact = result_valid && has_contact;

	`MTS_ASSERT_IMPLY(a_marker_last, result_valid && !has_contact, frame_last, "marker not last")
	`MTS_ASSERT_IMPLY(a_no_released, res_contact, contact_id != ID_RELEASED, "released id")
	`MTS_ASSERT_IMPLY(a_store_write, store_we, evt_acc && event_type == TYPE_ABS, "stray write")
	`MTS_ASSERT_NEXT(a_sync_busy, evt_acc && event_type == TYPE_SYNC, !event_ready, "no scan")

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the multitouch slot tracker: event stimulus, contact prediction and checking.
`timescale 1ns / 100ps

import mts_pkg::*;

// One reported contact, or the empty-frame marker
typedef struct packed {
	logic        has;
	logic [3:0]  slot;
	logic [31:0] id;
	logic [31:0] x;
	logic [31:0] y;
	logic        last;
} contact_t;

// Tracks slot state from accepted events and holds the contacts still owed by the block
class contact_scoreboard;
	logic [4:0]  slot_count;
	logic [31:0] cur_slot;
	logic [31:0] ids [SLOT_DEPTH_DEF];
	logic [31:0] xs [SLOT_DEPTH_DEF];
	logic [31:0] ys [SLOT_DEPTH_DEF];
	bit          touched [SLOT_DEPTH_DEF];
	contact_t    expected_contacts[$];
	int          mismatches;

	function new();
		slot_count = SLOT_COUNT_RST;
		cur_slot   = '0;
		mismatches = 0;
		for (int i = 0; i < SLOT_DEPTH_DEF; i++) begin
			ids[i]     = ID_IDLE;
			xs[i]      = '0;
			ys[i]      = '0;
			touched[i] = 1'b0;
		end
	endfunction

	function void write_slot_count(logic [4:0] value);
		slot_count = value;
	endfunction

	function int pending();
		return expected_contacts.size();
	endfunction

	// Apply one accepted event; a sync queues the contacts of the frame
	function void note_event(logic [15:0] etype, logic [15:0] ecode, logic [31:0] evalue);
		int       n_eff;
		int       reported;
		bit       in_range;
		contact_t c;
		n_eff = (slot_count > SLOT_DEPTH_DEF) ? SLOT_DEPTH_DEF : int'(slot_count);
		if (etype == TYPE_ABS) begin
			in_range = !cur_slot[31] && (cur_slot < 32'(n_eff));
			if (ecode == CODE_SLOT) begin
				cur_slot = evalue;
			end else if (in_range) begin
				case (ecode)
					CODE_TRACK: begin
						ids[int'(cur_slot)]     = evalue;
						touched[int'(cur_slot)] = 1'b1;
					end
					CODE_X: begin
						xs[int'(cur_slot)]      = evalue;
						touched[int'(cur_slot)] = 1'b1;
					end
					CODE_Y: begin
						ys[int'(cur_slot)]      = evalue;
						touched[int'(cur_slot)] = 1'b1;
					end
					default: ;
				endcase
			end
		end else if (etype == TYPE_SYNC) begin
			reported = 0;
			for (int i = 0; i < n_eff; i++) begin
				if (touched[i]) begin
					// released slots are cleared but not reported
					if (ids[i] != ID_RELEASED && reported < MAX_RESULTS) begin
						c = '{1'b1, 4'(i), ids[i], xs[i], ys[i], 1'b0};
						expected_contacts.push_back(c);
						reported++;
					end
					ids[i]     = ID_IDLE;
					touched[i] = 1'b0;
				end
			end
			if (reported == 0) begin
				c = '{1'b0, 4'd0, 32'd0, 32'd0, 32'd0, 1'b1};
				expected_contacts.push_back(c);
			end else begin
				c = expected_contacts.pop_back();
				c.last = 1'b1;
				expected_contacts.push_back(c);
			end
		end
	endfunction

	// Compare one accepted result against the oldest expected contact
	function void check_contact(contact_t got);
		contact_t want;
		if (expected_contacts.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: has=%0b slot=%0d id=%0d x=%0d y=%0d last=%0b",
					got.has, got.slot, $signed(got.id), $signed(got.x), $signed(got.y),
					got.last);
			return;
		end
		want = expected_contacts.pop_front();
		if (got.has !== want.has || got.slot !== want.slot || got.id !== want.id ||
				got.x !== want.x || got.y !== want.y || got.last !== want.last) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch exp: has=%0b slot=%0d id=%0d x=%0d y=%0d last=%0b",
					want.has, want.slot, $signed(want.id), $signed(want.x),
					$signed(want.y), want.last);
				$display("         got: has=%0b slot=%0d id=%0d x=%0d y=%0d last=%0b",
					got.has, got.slot, $signed(got.id), $signed(got.x), $signed(got.y),
					got.last);
			end
		end
	endfunction
endclass

module tb_top;
	// Drain wait, with margin over the longest sync scan
	localparam int DRAIN_CYCLES   = 48;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 40;

	// Events the block must ignore
	localparam logic [15:0] TYPE_KEY      = 16'h0001;
	localparam logic [15:0] TYPE_TOP      = 16'hffff;
	localparam logic [15:0] CODE_PRESSURE = 16'h003a;
	localparam logic [15:0] CODE_TOP      = 16'hffff;

	logic               clk;
	logic               arst_n;
	logic               slot_count_we;
	logic [4:0]         slot_count_wdata;
	logic               event_valid;
	logic               event_ready;
	logic [15:0]        event_type;
	logic [15:0]        event_code;
	logic signed [31:0] event_value;
	logic               result_valid;
	logic               result_ready;
	logic               has_contact;
	logic [3:0]         contact_slot;
	logic signed [31:0] contact_id;
	logic signed [31:0] contact_x;
	logic signed [31:0] contact_y;
	logic               frame_last;

	contact_scoreboard sb;
	int                events_sent;
	int                burst_left;
	logic [4:0]        phase_counts [7];

	multitouch_slot_tracker DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.slot_count_we    (slot_count_we),
		.slot_count_wdata (slot_count_wdata),
		.event_valid      (event_valid),
		.event_ready      (event_ready),
		.event_type       (event_type),
		.event_code       (event_code),
		.event_value      (event_value),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.has_contact      (has_contact),
		.contact_slot     (contact_slot),
		.contact_id       (contact_id),
		.contact_x        (contact_x),
		.contact_y        (contact_y),
		.frame_last       (frame_last)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Present one event and hold it until the transaction completes; idle gaps between bursts
	task automatic send_event(input logic [15:0] etype, input logic [15:0] ecode,
			input logic [31:0] evalue);
		event_valid <= 1'b1;
		event_type  <= etype;
		event_code  <= ecode;
		event_value <= evalue;
		@(posedge clk);
		while (!event_ready) @(posedge clk);
		sb.note_event(etype, ecode, evalue);
		events_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			event_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 8);
		end
	endtask

	// Update the slot count once the block has gone quiet
	task automatic write_slot_count(input logic [4:0] value);
		event_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		slot_count_we    <= 1'b1;
		slot_count_wdata <= value;
		@(posedge clk);
		slot_count_we <= 1'b0;
		sb.write_slot_count(value);
	endtask

	// Junk event: unknown type, unknown axis code, or fully random
	task automatic send_stray_event();
		logic [15:0] etype;
		logic [15:0] ecode;
		case ($urandom_range(0, 2))
			0: begin
				etype = TYPE_ABS;
				ecode = 16'($urandom_range(0, 65535));
			end
			1: begin
				etype = 16'($urandom_range(0, 65535));
				ecode = CODE_TRACK;
			end
			default: begin
				etype = 16'($urandom_range(0, 65535));
				ecode = 16'($urandom_range(0, 65535));
			end
		endcase
		send_event(etype, ecode, $urandom);
	endtask

	// One frame: a few slots selected and updated, then a sync
	task automatic send_touch_frame(input int n_eff);
		int          touches;
		int          top;
		logic [31:0] slot_val;
		logic [31:0] id_val;
		int          fields;
		top = (n_eff > 0) ? n_eff - 1 : 0;
		if (n_eff == 0)
			touches = $urandom_range(0, 3);
		else if ($urandom_range(0, 9) == 0)
			touches = n_eff;
		else
			touches = $urandom_range(0, (n_eff < 5) ? n_eff : 5);
		for (int t = 0; t < touches; t++) begin
			case ($urandom_range(0, 9))
				8:       slot_val = $urandom_range(n_eff, 31);
				9:       slot_val = $urandom;
				default: slot_val = $urandom_range(0, top);
			endcase
			if ($urandom_range(0, 7) != 0)
				send_event(TYPE_ABS, CODE_SLOT, slot_val);
			fields = $urandom_range(1, 7);
			if (fields[0]) begin
				case ($urandom_range(0, 5))
					0:       id_val = ID_RELEASED;
					1:       id_val = ID_IDLE;
					2:       id_val = $urandom;
					default: id_val = $urandom_range(0, 999);
				endcase
				send_event(TYPE_ABS, CODE_TRACK, id_val);
			end
			if ($urandom_range(0, 7) == 0)
				send_stray_event();
			if (fields[1])
				send_event(TYPE_ABS, CODE_X, ($urandom_range(0, 1) == 0) ? $urandom
					: $urandom_range(0, 4095));
			if (fields[2])
				send_event(TYPE_ABS, CODE_Y, ($urandom_range(0, 1) == 0) ? $urandom
					: $urandom_range(0, 4095));
		end
		// any code counts as a sync
		send_event(TYPE_SYNC, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
			: 16'd0, $urandom);
	endtask

	// Result side: check each transaction, then pick the next ready level
	initial begin : result_sink
		int stall_tick;
		int ready_mode;
		stall_tick   = 0;
		ready_mode   = 0;
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready)
				sb.check_contact('{has_contact, contact_slot, contact_id, contact_x,
					contact_y, frame_last});
			stall_tick++;
			if (stall_tick % 50 == 0)
				ready_mode = $urandom_range(0, 3);
			case (ready_mode)
				0:       result_ready <= 1'b1;
				1:       result_ready <= stall_tick[0];
				2:       result_ready <= ($urandom_range(0, 3) != 0);
				default: result_ready <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	// Watchdog on cycles without any transaction
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((event_valid && event_ready) || (result_valid && result_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		sb               = new();
		arst_n           = 1'b0;
		slot_count_we    = 1'b0;
		slot_count_wdata = '0;
		event_valid      = 1'b0;
		event_type       = '0;
		event_code       = '0;
		event_value      = '0;
		events_sent      = 0;
		burst_left       = 4;
		phase_counts     = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd16, 5'd0, 5'd0};
		phase_counts[5]  = 5'($urandom_range(2, 15));
		phase_counts[6]  = 5'($urandom_range(0, 31));
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty frame, field extremes, released id, out-of-range slots
		send_event(TYPE_SYNC, 16'd0, 32'd0);
		send_event(TYPE_ABS, CODE_SLOT, 32'd0);
		send_event(TYPE_ABS, CODE_TRACK, 32'h7fff_ffff);
		send_event(TYPE_ABS, CODE_X, 32'h8000_0000);
		send_event(TYPE_ABS, CODE_Y, 32'hffff_ffff);
		send_event(TYPE_ABS, CODE_SLOT, 32'd15);
		send_event(TYPE_ABS, CODE_TRACK, 32'h8000_0000);
		send_event(TYPE_ABS, CODE_X, 32'h7fff_ffff);
		send_event(TYPE_ABS, CODE_Y, 32'd0);
		send_event(TYPE_ABS, CODE_SLOT, 32'd5);
		send_event(TYPE_ABS, CODE_TRACK, ID_RELEASED);
		send_event(TYPE_ABS, CODE_SLOT, 32'hffff_ffff);
		send_event(TYPE_ABS, CODE_X, 32'd123);
		send_event(TYPE_ABS, CODE_SLOT, 32'd16);
		send_event(TYPE_ABS, CODE_TRACK, 32'd5);
		send_event(TYPE_ABS, CODE_PRESSURE, 32'd77);
		send_event(TYPE_TOP, CODE_TOP, 32'h5555_aaaa);
		send_event(TYPE_KEY, CODE_TRACK, 32'haaaa_5555);
		send_event(TYPE_SYNC, CODE_TOP, 32'hffff_ffff);
		// slot touched by Y only reports the idle id
		send_event(TYPE_ABS, CODE_SLOT, 32'd15);
		send_event(TYPE_ABS, CODE_Y, 32'd42);
		send_event(TYPE_SYNC, 16'd0, 32'd0);

		// Random frames under a series of slot counts
		foreach (phase_counts[p]) begin
			int phase_end;
			int n_eff;
			write_slot_count(phase_counts[p]);
			n_eff     = (phase_counts[p] > SLOT_DEPTH_DEF) ? SLOT_DEPTH_DEF : phase_counts[p];
			phase_end = events_sent + PHASE_ITEMS;
			while (events_sent < phase_end)
				send_touch_frame(n_eff);
		end

		// Drain
		event_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
